>>> hw/rtl/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

    // Hue is measured in sixteenths of a degree, so one 60-degree sector spans 960 units.
    localparam logic [12:0] SECTOR_UNITS = 13'd960;
    localparam logic [12:0] HUE_PERIOD   = 13'd1920;
    localparam int          NUM_BOUNDS   = 8;

    // Full scale of one 8-bit channel, and of a product of two of them.
    localparam logic [7:0]  FULL_SCALE = 8'd255;
    localparam logic [15:0] MAX_LEVEL  = 16'd65025;

    // Reciprocals with a 2^24 scale. Both are exact floors over the value ranges used here.
    localparam int          RECIP_SHIFT = 24;
    localparam logic [20:0] RECIP_15    = 21'd1118482;
    localparam logic [16:0] RECIP_255   = 17'd65794;

    typedef logic [3:0] sector_t;

    localparam sector_t SEC_RED_YELLOW    = 4'd0;
    localparam sector_t SEC_YELLOW_GREEN  = 4'd1;
    localparam sector_t SEC_GREEN_CYAN    = 4'd2;
    localparam sector_t SEC_CYAN_BLUE     = 4'd3;
    localparam sector_t SEC_BLUE_MAGENTA  = 4'd4;
    localparam sector_t SEC_LAST          = 4'd8;

endpackage

`default_nettype wire

>>> hw/rtl/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
`default_nettype none

// HSV to RGB pixel converter.
// Input beats arrive on the s_axis channel: hue in sixteenths of a degree (0 to 5759),
// saturation and value as 8-bit fractions of 255. Each input beat gives exactly one output
// beat on the m_axis channel with 8-bit red, green and blue, in the same order.
// Hue codes above 5759 take the channel routing of the last sector (magenta to red).
// The datapath is a five-stage pipeline: chroma product and sector search, chroma times
// ramp weight, divide by 960 through a reciprocal multiply, channel routing and offset add,
// and divide by 255 through a reciprocal multiply. Each stage holds at most one multiplier
// per channel.
// An accepted beat moves through the stage registers in order and shows on m_axis from
// the last one; a stall can hold it in any stage on the way.
// Throughput is one pixel per clock without stalls; the multiplier stages set the clock rate.
// When the receiver stalls, the output stage holds its beat and earlier stages keep
// moving until they fill, so up to five beats are absorbed before s_axis_tready drops.
// Each stage is ready when it is empty or when the stage after it moves on.
// Reset clears all valid bits; the pipeline comes out of reset empty and ready.
module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // hue[12:0], saturation[20:13], brightness[28:21]

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

    // Unpacked input fields.
    logic [12:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;

    assign hue        = s_axis_tdata[12:0];
    assign saturation = s_axis_tdata[20:13];
    assign brightness = s_axis_tdata[28:21];

    // Stage valid bits and the backward ready chain.
    logic [4:0] valid_reg;
    logic [4:0] valid_next;
    logic [4:0] stage_ready;
    logic [4:0] stage_load;

    always_comb
    begin
        stage_ready[4] = !valid_reg[4] || m_axis_tready;
        stage_ready[3] = !valid_reg[3] || stage_ready[4];
        stage_ready[2] = !valid_reg[2] || stage_ready[3];
        stage_ready[1] = !valid_reg[1] || stage_ready[2];
        stage_ready[0] = !valid_reg[0] || stage_ready[1];

        stage_load[0] = stage_ready[0] && s_axis_tvalid;
        stage_load[1] = stage_ready[1] && valid_reg[0];
        stage_load[2] = stage_ready[2] && valid_reg[1];
        stage_load[3] = stage_ready[3] && valid_reg[2];
        stage_load[4] = stage_ready[4] && valid_reg[3];

        valid_next[0] = stage_ready[0] ? s_axis_tvalid : valid_reg[0];
        valid_next[1] = stage_ready[1] ? valid_reg[0]  : valid_reg[1];
        valid_next[2] = stage_ready[2] ? valid_reg[1]  : valid_reg[2];
        valid_next[3] = stage_ready[3] ? valid_reg[2]  : valid_reg[3];
        valid_next[4] = stage_ready[4] ? valid_reg[3]  : valid_reg[4];
    end

    assign s_axis_tready = stage_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: chroma C = S * V, sector count and position within the 120-degree period.
    sector_t     s1_sector_reg, s1_sector_next;
    logic [10:0] s1_pos_reg, s1_pos_next;
    logic [15:0] s1_chroma_reg, s1_chroma_next;
    logic [7:0]  s1_value_reg;
    logic [12:0] s1_period_base;
    logic [12:0] s1_pos_wide;

    always_comb
    begin
        s1_sector_next = '0;
        for (int k = 1; k <= NUM_BOUNDS; k++)
        begin
            if (hue >= 13'(k * 960))
            begin
                s1_sector_next = s1_sector_next + 4'd1;
            end
        end
        s1_period_base = 13'({10'b0, s1_sector_next[3:1]} * HUE_PERIOD);
        s1_pos_wide    = hue - s1_period_base;
        s1_pos_next    = s1_pos_wide[10:0];
        s1_chroma_next = {8'b0, saturation} * {8'b0, brightness};
    end

    // Stage 2: ramp weight (960 - distance) times C, and the offset m = 255 * V - C.
    sector_t     s2_sector_reg;
    logic [25:0] s2_prod_reg, s2_prod_next;
    logic [15:0] s2_chroma_reg;
    logic [15:0] s2_offset_reg, s2_offset_next;
    logic [9:0]  s2_weight;
    logic [12:0] s2_weight_wide;

    always_comb
    begin
        // Rising ramp in the first half of the period, falling ramp in the second.
        s2_weight_wide = HUE_PERIOD - {2'b0, s1_pos_reg};
        if (s1_pos_reg < SECTOR_UNITS[10:0])
        begin
            s2_weight = s1_pos_reg[9:0];
        end
        else
        begin
            s2_weight = s2_weight_wide[9:0];
        end
        s2_prod_next   = {10'b0, s1_chroma_reg} * {16'b0, s2_weight};
        s2_offset_next = ({s1_value_reg, 8'b0} - {8'b0, s1_value_reg}) - s1_chroma_reg;
    end

    // Stage 3: X = product / 960, done as (product >> 6) / 15 with a reciprocal multiply.
    sector_t     s3_sector_reg;
    logic [15:0] s3_x_reg, s3_x_next;
    logic [15:0] s3_chroma_reg;
    logic [15:0] s3_offset_reg;
    logic [40:0] s3_recip_prod;

    always_comb
    begin
        s3_recip_prod = {21'b0, s2_prod_reg[25:6]} * {20'b0, RECIP_15};
        s3_x_next     = s3_recip_prod[RECIP_SHIFT +: 16];
    end

    // Stage 4: route C, X and zero to the channels by sector and add the offset.
    logic [15:0] s4_red_sum_reg, s4_red_sum_next;
    logic [15:0] s4_green_sum_reg, s4_green_sum_next;
    logic [15:0] s4_blue_sum_reg, s4_blue_sum_next;
    logic [15:0] s4_red_part, s4_green_part, s4_blue_part;

    always_comb
    begin
        case (s3_sector_reg)
            SEC_RED_YELLOW:
            begin
                s4_red_part   = s3_chroma_reg;
                s4_green_part = s3_x_reg;
                s4_blue_part  = '0;
            end
            SEC_YELLOW_GREEN:
            begin
                s4_red_part   = s3_x_reg;
                s4_green_part = s3_chroma_reg;
                s4_blue_part  = '0;
            end
            SEC_GREEN_CYAN:
            begin
                s4_red_part   = '0;
                s4_green_part = s3_chroma_reg;
                s4_blue_part  = s3_x_reg;
            end
            SEC_CYAN_BLUE:
            begin
                s4_red_part   = '0;
                s4_green_part = s3_x_reg;
                s4_blue_part  = s3_chroma_reg;
            end
            SEC_BLUE_MAGENTA:
            begin
                s4_red_part   = s3_x_reg;
                s4_green_part = '0;
                s4_blue_part  = s3_chroma_reg;
            end
            default:
            begin
                // Magenta to red, and every hue code past the legal range.
                s4_red_part   = s3_chroma_reg;
                s4_green_part = '0;
                s4_blue_part  = s3_x_reg;
            end
        endcase
        s4_red_sum_next   = s4_red_part + s3_offset_reg;
        s4_green_sum_next = s4_green_part + s3_offset_reg;
        s4_blue_sum_next  = s4_blue_part + s3_offset_reg;
    end

    // Stage 5: each channel is floor(sum / 255), again through a reciprocal multiply.
    logic [7:0]  s5_red_reg, s5_red_next;
    logic [7:0]  s5_green_reg, s5_green_next;
    logic [7:0]  s5_blue_reg, s5_blue_next;
    logic [32:0] s5_red_prod, s5_green_prod, s5_blue_prod;

    always_comb
    begin
        s5_red_prod   = {17'b0, s4_red_sum_reg}   * {16'b0, RECIP_255};
        s5_green_prod = {17'b0, s4_green_sum_reg} * {16'b0, RECIP_255};
        s5_blue_prod  = {17'b0, s4_blue_sum_reg}  * {16'b0, RECIP_255};
        s5_red_next   = s5_red_prod[RECIP_SHIFT +: 8];
        s5_green_next = s5_green_prod[RECIP_SHIFT +: 8];
        s5_blue_next  = s5_blue_prod[RECIP_SHIFT +: 8];
    end

    // Payload registers load only when their stage takes a new beat.
    always_ff @(posedge clk)
    begin
        if (stage_load[0])
        begin
            s1_sector_reg <= s1_sector_next;
            s1_pos_reg    <= s1_pos_next;
            s1_chroma_reg <= s1_chroma_next;
            s1_value_reg  <= brightness;
        end
        if (stage_load[1])
        begin
            s2_sector_reg <= s1_sector_reg;
            s2_prod_reg   <= s2_prod_next;
            s2_chroma_reg <= s1_chroma_reg;
            s2_offset_reg <= s2_offset_next;
        end
        if (stage_load[2])
        begin
            s3_sector_reg <= s2_sector_reg;
            s3_x_reg      <= s3_x_next;
            s3_chroma_reg <= s2_chroma_reg;
            s3_offset_reg <= s2_offset_reg;
        end
        if (stage_load[3])
        begin
            s4_red_sum_reg   <= s4_red_sum_next;
            s4_green_sum_reg <= s4_green_sum_next;
            s4_blue_sum_reg  <= s4_blue_sum_next;
        end
        if (stage_load[4])
        begin
            s5_red_reg   <= s5_red_next;
            s5_green_reg <= s5_green_next;
            s5_blue_reg  <= s5_blue_next;
        end
    end

    assign m_axis_tvalid = valid_reg[4];
    assign m_axis_tdata  = {s5_blue_reg, s5_green_reg, s5_red_reg};

    // An empty pipeline must always take a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg == '0) |-> s_axis_tready)
    else $error("empty pipeline is not ready");

    // A first-stage beat that cannot move on keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && !stage_ready[1]) |=>
            (valid_reg[0] && $stable(s1_chroma_reg) && $stable(s1_sector_reg)))
    else $error("stalled first stage lost its beat");

    // The sector search never counts past the last bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] |-> (s1_sector_reg <= SEC_LAST))
    else $error("sector count out of range");

    // The secondary component never exceeds chroma.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] |-> (s3_x_reg <= s3_chroma_reg))
    else $error("secondary component exceeds chroma");

    // Part plus offset stays within full scale, so no channel wraps.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] |-> ((s4_red_sum_reg <= MAX_LEVEL) && (s4_green_sum_reg <= MAX_LEVEL)
            && (s4_blue_sum_reg <= MAX_LEVEL)))
    else $error("channel sum exceeds full scale");

endmodule

`default_nettype wire
